@@ design/fca_pkg.sv @@
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the frame co-add averaging block: register
// map, register reset values, fixed result field widths and the sideband
// record that travels with each result through the arithmetic pipelines.
// ----------------------------------------------------------------------------
package fca_pkg;

  // register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_FRAME_PIXELS   = 2'd0;
  localparam logic [1:0] REG_COADD_COUNT    = 2'd1;
  localparam logic [1:0] REG_AVERAGE_ENABLE = 2'd2;
  localparam logic [1:0] REG_RMS_ENABLE     = 2'd3;

  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;
  localparam int FRAME_PIXELS_W  = 17;
  localparam int COADD_COUNT_W   = 11;
  localparam int INDEX_W         = 16;
  localparam int RESULT_W        = 24;

  // register reset values
  localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RST = 17'd65536;
  localparam logic [COADD_COUNT_W-1:0]  COADD_COUNT_RST  = 11'd100;

  // saturation limits of the Q8 results
  localparam logic [RESULT_W-1:0] AVG_POS_MAX = 24'h7FFFFF;
  localparam logic [RESULT_W-1:0] AVG_NEG_MIN = 24'h800000;
  localparam logic [RESULT_W-1:0] RMS_MAX     = 24'hFFFFFF;

  // sideband carried alongside a result word
  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic               last;
    logic               avg_en;
    logic               rms_en;
    logic               avg_neg;
  } meta_t;

endpackage

@@ design/fca_ram.sv @@
// ----------------------------------------------------------------------------
// fca_ram
// Generic single-clock RAM, one write port and one read port with enable,
// registered read data (old contents returned on a same-address collision).
// ----------------------------------------------------------------------------
module fca_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 65536
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/fca_div.sv @@
// ----------------------------------------------------------------------------
// fca_div
// Two restoring division lanes sharing one divisor, one quotient bit per
// stage, DW stages. Lane a gives quotient and remainder, lane r the quotient.
// ----------------------------------------------------------------------------
module fca_div #(
  parameter int DW = 57,
  parameter int CW = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  fca_pkg::meta_t      in_meta,
  input  logic [CW-1:0]       in_den,
  input  logic [DW-1:0]       in_a,
  input  logic [DW-1:0]       in_r,
  output logic                out_valid,
  output fca_pkg::meta_t      out_meta,
  output logic [DW-1:0]       out_a_quo,
  output logic [CW-1:0]       out_a_rem,
  output logic [DW-1:0]       out_r_quo
);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [CW+DW-1:0] div_step(input logic [CW-1:0] rem,
                                                input logic [DW-1:0] num,
                                                input logic [CW-1:0] den);
    logic [CW:0] t;
    logic [CW:0] d;
    logic        ge;
    t  = {rem, num[DW-1]};
    d  = t - {1'b0, den};
    ge = (t >= {1'b0, den});
    div_step = {(ge ? d[CW-1:0] : t[CW-1:0]), num[DW-2:0], ge};
  endfunction

  logic                 vld_r  [DW];
  fca_pkg::meta_t       meta_r [DW];
  logic [CW-1:0]        den_r  [DW];
  logic [DW-1:0]        an_r   [DW];
  logic [CW-1:0]        ar_r   [DW];
  logic [DW-1:0]        rn_r   [DW];
  logic [CW-1:0]        rr_r   [DW];

  logic                 vld_p  [DW];
  fca_pkg::meta_t       meta_p [DW];
  logic [CW-1:0]        den_p  [DW];
  logic [DW-1:0]        an_p   [DW];
  logic [CW-1:0]        ar_p   [DW];
  logic [DW-1:0]        rn_p   [DW];
  logic [CW-1:0]        rr_p   [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [CW+DW-1:0] a_nx;
    logic [CW+DW-1:0] r_nx;

    // stage input: port for the first stage, previous stage otherwise
    if (i == 0) begin : g_head
      assign vld_p[i]  = in_valid;
      assign meta_p[i] = in_meta;
      assign den_p[i]  = in_den;
      assign an_p[i]   = in_a;
      assign ar_p[i]   = '0;
      assign rn_p[i]   = in_r;
      assign rr_p[i]   = '0;
    end else begin : g_body
      assign vld_p[i]  = vld_r[i-1];
      assign meta_p[i] = meta_r[i-1];
      assign den_p[i]  = den_r[i-1];
      assign an_p[i]   = an_r[i-1];
      assign ar_p[i]   = ar_r[i-1];
      assign rn_p[i]   = rn_r[i-1];
      assign rr_p[i]   = rr_r[i-1];
    end

    assign a_nx = div_step(ar_p[i], an_p[i], den_p[i]);
    assign r_nx = div_step(rr_p[i], rn_p[i], den_p[i]);

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p[i];
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[i] <= meta_p[i];
        den_r[i]  <= den_p[i];
        ar_r[i]   <= a_nx[CW+DW-1:DW];
        an_r[i]   <= a_nx[DW-1:0];
        rr_r[i]   <= r_nx[CW+DW-1:DW];
        rn_r[i]   <= r_nx[DW-1:0];
      end
    end
  end

  assign out_valid = vld_r[DW-1];
  assign out_meta  = meta_r[DW-1];
  assign out_a_quo = an_r[DW-1];
  assign out_a_rem = ar_r[DW-1];
  assign out_r_quo = rn_r[DW-1];

endmodule

@@ design/fca_sqrt.sv @@
// ----------------------------------------------------------------------------
// fca_sqrt
// Pipelined integer square root, digit by digit, one root bit per stage,
// RW stages. Carries the result sideband and the finished average along.
// ----------------------------------------------------------------------------
module fca_sqrt #(
  parameter int RW = 29
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  fca_pkg::meta_t                in_meta,
  input  logic [fca_pkg::RESULT_W-1:0]  in_avg,
  input  logic [2*RW-1:0]               in_x,
  output logic                          out_valid,
  output fca_pkg::meta_t                out_meta,
  output logic [fca_pkg::RESULT_W-1:0]  out_avg,
  output logic [RW-1:0]                 out_root
);

  // one step: bring down two radicand bits, try root*4+1
  function automatic logic [RW+1+RW+2*RW-1:0] sq_step(input logic [RW:0]     rem,
                                                      input logic [RW-1:0]   root,
                                                      input logic [2*RW-1:0] x);
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic [RW+2:0] d;
    logic          ge;
    t     = {rem, x[2*RW-1:2*RW-2]};
    trial = {1'b0, root, 2'b01};
    d     = t - trial;
    ge    = (t >= trial);
    sq_step = {(ge ? d[RW:0] : t[RW:0]), root[RW-2:0], ge, x[2*RW-3:0], 2'b00};
  endfunction

  localparam int SW = RW + 1 + RW + 2 * RW;

  logic                          vld_r  [RW];
  fca_pkg::meta_t                meta_r [RW];
  logic [fca_pkg::RESULT_W-1:0]  avg_r  [RW];
  logic [RW:0]                   rem_r  [RW];
  logic [RW-1:0]                 root_r [RW];
  logic [2*RW-1:0]               x_r    [RW];

  logic                          vld_p  [RW];
  fca_pkg::meta_t                meta_p [RW];
  logic [fca_pkg::RESULT_W-1:0]  avg_p  [RW];
  logic [RW:0]                   rem_p  [RW];
  logic [RW-1:0]                 root_p [RW];
  logic [2*RW-1:0]               x_p    [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [SW-1:0] nx;

    // stage input
    if (i == 0) begin : g_head
      assign vld_p[i]  = in_valid;
      assign meta_p[i] = in_meta;
      assign avg_p[i]  = in_avg;
      assign rem_p[i]  = '0;
      assign root_p[i] = '0;
      assign x_p[i]    = in_x;
    end else begin : g_body
      assign vld_p[i]  = vld_r[i-1];
      assign meta_p[i] = meta_r[i-1];
      assign avg_p[i]  = avg_r[i-1];
      assign rem_p[i]  = rem_r[i-1];
      assign root_p[i] = root_r[i-1];
      assign x_p[i]    = x_r[i-1];
    end

    assign nx = sq_step(rem_p[i], root_p[i], x_p[i]);

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p[i];
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[i] <= meta_p[i];
        avg_r[i]  <= avg_p[i];
        rem_r[i]  <= nx[SW-1:SW-RW-1];
        root_r[i] <= nx[3*RW-1:2*RW];
        x_r[i]    <= nx[2*RW-1:0];
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_meta  = meta_r[RW-1];
  assign out_avg   = avg_r[RW-1];
  assign out_root  = root_r[RW-1];

endmodule

@@ design/frame_coadd_average_rms.sv @@
// ----------------------------------------------------------------------------
// frame_coadd_average_rms
// Per-pixel co-add of a frame stream into a sum memory and a sum-of-squares
// memory, with a floored Q8 average and RMS emitted on the completing frame.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------
//   pixel    | in        | pixel_valid / pixel_ready  | pixel_value
//   result   | out       | result_valid / result_ready| pixel_index, averages
//   config   | in        | APB psel/penable/pready    | paddr, pwdata, prdata
//
// One pixel per cycle unless stalled. Results pass the accumulate and dividend
// stages, divider (DW = 2*PIXEL_BITS + 15 + clog2(MAX_COADD)) and root (RW =
// DW/2 rounded up). Memory read-modify-write reads on acceptance, writes back
// from the accumulate stage and bypasses a repeated pixel position. A stalled
// result register freezes the whole pipeline, and pixel_ready follows it. No
// clearing pass: the stores are written by the first frame of each run. Reset
// is synchronous and clears control only.
// ----------------------------------------------------------------------------
module frame_coadd_average_rms #(
  parameter int MAX_PIXELS = 65536,
  parameter int MAX_COADD  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // pixel input
  input  logic                                  pixel_valid,
  output logic                                  pixel_ready,
  input  logic signed [PIXEL_BITS-1:0]          pixel_value,
  // result output
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [fca_pkg::INDEX_W-1:0]           pixel_index,
  output logic signed [fca_pkg::RESULT_W-1:0]   average_value,
  output logic [fca_pkg::RESULT_W-1:0]          rms_value,
  output logic                                  average_valid,
  output logic                                  rms_valid,
  output logic                                  last_in_frame,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fca_pkg::ADDR_W-1:0]            paddr,
  input  logic [fca_pkg::DATA_W-1:0]            pwdata,
  output logic [fca_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PX_W  = $clog2(MAX_PIXELS + 1);
  localparam int FS_W  = (PX_W > fca_pkg::FRAME_PIXELS_W) ? PX_W : fca_pkg::FRAME_PIXELS_W;
  localparam int FRM_W = (MAX_COADD > 1) ? $clog2(MAX_COADD) : 1;
  localparam int CNT_W = $clog2(MAX_COADD + 1);
  localparam int CS_W  = (CNT_W > fca_pkg::COADD_COUNT_W) ? CNT_W : fca_pkg::COADD_COUNT_W;
  localparam int CLG   = $clog2(MAX_COADD);
  localparam int SUM_W = PIXEL_BITS + CLG;
  localparam int SQ_W  = 2 * PIXEL_BITS - 1 + CLG;
  localparam int DW    = SQ_W + 16;
  localparam int RW    = (DW + 1) / 2;
  localparam int RX_W  = (RW > fca_pkg::RESULT_W) ? RW : fca_pkg::RESULT_W;

  // configuration registers
  logic [fca_pkg::FRAME_PIXELS_W-1:0] frame_pixels;
  logic [fca_pkg::COADD_COUNT_W-1:0]  coadd_count;
  logic                               average_enable;
  logic                               rms_enable;
  logic                               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels   <= fca_pkg::FRAME_PIXELS_RST;
      coadd_count    <= fca_pkg::COADD_COUNT_RST;
      average_enable <= 1'b1;
      rms_enable     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fca_pkg::REG_FRAME_PIXELS:   frame_pixels   <= pwdata[fca_pkg::FRAME_PIXELS_W-1:0];
        fca_pkg::REG_COADD_COUNT:    coadd_count    <= pwdata[fca_pkg::COADD_COUNT_W-1:0];
        fca_pkg::REG_AVERAGE_ENABLE: average_enable <= pwdata[0];
        fca_pkg::REG_RMS_ENABLE:     rms_enable     <= pwdata[0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      fca_pkg::REG_FRAME_PIXELS:   prdata = fca_pkg::DATA_W'(frame_pixels);
      fca_pkg::REG_COADD_COUNT:    prdata = fca_pkg::DATA_W'(coadd_count);
      fca_pkg::REG_AVERAGE_ENABLE: prdata = fca_pkg::DATA_W'(average_enable);
      fca_pkg::REG_RMS_ENABLE:     prdata = fca_pkg::DATA_W'(rms_enable);
    endcase
  end

  // pipeline advance: everything moves unless the result word is held
  logic adv;
  logic pix_acc;

  assign adv         = !result_valid || result_ready;
  assign pixel_ready = adv;
  assign pix_acc     = pixel_valid && adv;

  // position and frame counters
  logic [POS_W-1:0] pos;
  logic [FRM_W-1:0] frames;
  logic [FS_W-1:0]  fp_ext;
  logic [FS_W-1:0]  fsz;
  logic [FS_W:0]    pos_inc;
  logic [CS_W-1:0]  cs_ext;
  logic [CS_W-1:0]  csz;
  logic [CNT_W-1:0] count;
  logic             last;
  logic             done;

  always_comb begin
    fp_ext  = FS_W'(frame_pixels);
    if (fp_ext == '0) begin
      fsz = FS_W'(1);
    end else if (fp_ext > FS_W'(MAX_PIXELS)) begin
      fsz = FS_W'(MAX_PIXELS);
    end else begin
      fsz = fp_ext;
    end
    cs_ext = CS_W'(coadd_count);
    if (cs_ext == '0) begin
      csz = CS_W'(1);
    end else if (cs_ext > CS_W'(MAX_COADD)) begin
      csz = CS_W'(MAX_COADD);
    end else begin
      csz = cs_ext;
    end
    pos_inc = (FS_W + 1)'(pos) + (FS_W + 1)'(1);
    last    = pos_inc >= (FS_W + 1)'(fsz);
    count   = CNT_W'(frames) + CNT_W'(1);
    done    = CS_W'(count) >= csz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      frames <= '0;
    end else if (pix_acc) begin
      if (last) begin
        pos    <= '0;
        frames <= done ? '0 : FRM_W'(count);
      end else begin
        pos    <= POS_W'(pos_inc);
      end
    end
  end

  // accumulate stage: memory word arrives, sum is formed and written back
  logic                   s1_valid;
  logic [POS_W-1:0]       s1_pos;
  logic [SUM_W-1:0]       s1_v;
  logic [SQ_W-1:0]        s1_sq;
  logic                   s1_first;
  logic                   s1_emit;
  logic                   s1_rms_en;
  logic [CNT_W-1:0]       s1_count;
  fca_pkg::meta_t         s1_meta;
  logic                   s1_fwd;
  logic [SUM_W-1:0]       fwd_sum;
  logic [SQ_W-1:0]        fwd_sq;
  logic [SUM_W-1:0]       sum_q;
  logic [SQ_W-1:0]        sq_q;
  logic [SUM_W-1:0]       new_sum;
  logic [SQ_W-1:0]        new_sq;
  logic [2*PIXEL_BITS-1:0] pix_sq;

  assign pix_sq = (2 * PIXEL_BITS)'(pixel_value) * (2 * PIXEL_BITS)'(pixel_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos              <= pos;
      s1_v                <= SUM_W'(pixel_value);
      s1_sq               <= SQ_W'(pix_sq);
      s1_first            <= (frames == '0);
      s1_emit             <= done && (average_enable || rms_enable);
      s1_rms_en           <= rms_enable;
      s1_count            <= count;
      s1_meta.pixel_index <= fca_pkg::INDEX_W'(pos);
      s1_meta.last        <= last;
      s1_meta.avg_en      <= average_enable;
      s1_meta.rms_en      <= rms_enable;
      s1_meta.avg_neg     <= 1'b0;
      // the word read at this edge misses the write-back of the same edge
      s1_fwd              <= pix_acc && s1_valid && (pos == s1_pos);
      fwd_sum             <= new_sum;
      fwd_sq              <= new_sq;
    end
  end

  // read-modify-write with bypass of the word written in the same cycle
  always_comb begin
    new_sum = s1_first ? s1_v : (s1_fwd ? fwd_sum : sum_q) + s1_v;
    new_sq  = s1_first ? s1_sq
                       : (((s1_fwd && s1_rms_en) ? fwd_sq : sq_q) + s1_sq);
  end

  fca_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_PIXELS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (adv && s1_valid),
    .waddr (s1_pos),
    .wdata (new_sum),
    .re    (pix_acc),
    .raddr (pos),
    .rdata (sum_q)
  );

  fca_ram #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_PIXELS)
  ) u_sq_ram (
    .clk   (clk),
    .we    (adv && s1_valid && s1_rms_en),
    .waddr (s1_pos),
    .wdata (new_sq),
    .re    (pix_acc),
    .raddr (pos),
    .rdata (sq_q)
  );

  // dividend stage: magnitude of sum*256 and sumsq*65536
  logic             s2_valid;
  fca_pkg::meta_t   s2_meta;
  logic [CNT_W-1:0] s2_count;
  logic [DW-1:0]    s2_a;
  logic [DW-1:0]    s2_r;
  logic [SUM_W-1:0] sum_mag;

  assign sum_mag = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : new_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta         <= '{pixel_index: s1_meta.pixel_index,
                           last:        s1_meta.last,
                           avg_en:      s1_meta.avg_en,
                           rms_en:      s1_meta.rms_en,
                           avg_neg:     new_sum[SUM_W-1]};
      s2_count        <= s1_count;
      s2_a            <= DW'({sum_mag, 8'h00});
      s2_r            <= {new_sq, 16'h0000};
    end
  end

  // division by the frame count
  logic             dv_valid;
  fca_pkg::meta_t   dv_meta;
  logic [DW-1:0]    dv_a_quo;
  logic [CNT_W-1:0] dv_a_rem;
  logic [DW-1:0]    dv_r_quo;

  fca_div #(
    .DW (DW),
    .CW (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s2_valid),
    .in_meta   (s2_meta),
    .in_den    (s2_count),
    .in_a      (s2_a),
    .in_r      (s2_r),
    .out_valid (dv_valid),
    .out_meta  (dv_meta),
    .out_a_quo (dv_a_quo),
    .out_a_rem (dv_a_rem),
    .out_r_quo (dv_r_quo)
  );

  // floor towards minus infinity and saturate the average
  logic [DW-1:0]                avg_mag;
  logic [fca_pkg::RESULT_W-1:0] avg_sat;

  always_comb begin
    avg_mag = dv_a_quo + DW'(dv_meta.avg_neg && (dv_a_rem != '0));
    if (dv_meta.avg_neg) begin
      avg_sat = (avg_mag > DW'(fca_pkg::AVG_NEG_MIN)) ? fca_pkg::AVG_NEG_MIN
                                                     : fca_pkg::RESULT_W'(-avg_mag);
    end else begin
      avg_sat = (avg_mag > DW'(fca_pkg::AVG_POS_MAX)) ? fca_pkg::AVG_POS_MAX
                                                     : fca_pkg::RESULT_W'(avg_mag);
    end
  end

  // square root of the mean square
  logic                         sr_valid;
  fca_pkg::meta_t               sr_meta;
  logic [fca_pkg::RESULT_W-1:0] sr_avg;
  logic [RW-1:0]                sr_root;

  fca_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dv_valid),
    .in_meta   (dv_meta),
    .in_avg    (avg_sat),
    .in_x      ((2 * RW)'(dv_r_quo)),
    .out_valid (sr_valid),
    .out_meta  (sr_meta),
    .out_avg   (sr_avg),
    .out_root  (sr_root)
  );

  // result register
  logic [RX_W-1:0]              root_ext;
  logic [fca_pkg::RESULT_W-1:0] rms_sat;

  assign root_ext = RX_W'(sr_root);
  assign rms_sat  = (root_ext > RX_W'(fca_pkg::RMS_MAX)) ? fca_pkg::RMS_MAX
                                                        : fca_pkg::RESULT_W'(root_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= sr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_index   <= sr_meta.pixel_index;
      average_value <= sr_meta.avg_en ? sr_avg : '0;
      rms_value     <= sr_meta.rms_en ? rms_sat : '0;
      average_valid <= sr_meta.avg_en;
      rms_valid     <= sr_meta.rms_en;
      last_in_frame <= sr_meta.last;
    end
  end

endmodule

@@ tb/coadd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coadd_checker
// Watches the pixel, result and configuration channels of the frame co-add
// block, keeps its own per-pixel sums and counters, predicts each average and
// RMS word and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module coadd_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  input  logic                                pixel_ready,
  input  logic signed [15:0]                  pixel_value,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  logic [fca_pkg::INDEX_W-1:0]         pixel_index,
  input  logic signed [fca_pkg::RESULT_W-1:0] average_value,
  input  logic [fca_pkg::RESULT_W-1:0]        rms_value,
  input  logic                                average_valid,
  input  logic                                rms_valid,
  input  logic                                last_in_frame,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fca_pkg::ADDR_W-1:0]          paddr,
  input  logic [fca_pkg::DATA_W-1:0]          pwdata,
  input  logic                                pready,
  output int                                  errors,
  output int                                  pending
);

  typedef struct packed {
    logic [fca_pkg::INDEX_W-1:0]         index;
    logic signed [fca_pkg::RESULT_W-1:0] average;
    logic [fca_pkg::RESULT_W-1:0]        rms;
    logic                                avg_on;
    logic                                rms_on;
    logic                                last;
  } coadd_word_t;

  localparam int PIXELS_MAX = 65536;
  localparam int FRAMES_MAX = 1024;

  longint          pixel_sum [PIXELS_MAX];
  longint unsigned square_sum [PIXELS_MAX];
  int              position;
  int              frame_count;
  logic [fca_pkg::FRAME_PIXELS_W-1:0] frame_size_reg;
  logic [fca_pkg::COADD_COUNT_W-1:0]  coadd_reg;
  logic                               avg_on_reg;
  logic                               rms_on_reg;
  coadd_word_t                        expected_words [$];

  assign pending = expected_words.size();

  // integer square root, one result bit per step
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x)
        root = trial;
    end
    return root;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    coadd_word_t     got_w;
    coadd_word_t     want_w;
    longint          v;
    longint          num;
    longint          avg;
    longint unsigned sq;
    longint unsigned scaled;
    longint unsigned root;
    int              fsize;
    int              csize;
    int              pos;
    int              count;
    logic            done;
    logic            last;
    if (rst) begin
      position       <= 0;
      frame_count    <= 0;
      frame_size_reg <= fca_pkg::FRAME_PIXELS_RST;
      coadd_reg      <= fca_pkg::COADD_COUNT_RST;
      avg_on_reg     <= 1'b1;
      rms_on_reg     <= 1'b0;
      errors          = 0;
      expected_words.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fca_pkg::REG_FRAME_PIXELS:
            frame_size_reg <= pwdata[fca_pkg::FRAME_PIXELS_W-1:0];
          fca_pkg::REG_COADD_COUNT:
            coadd_reg      <= pwdata[fca_pkg::COADD_COUNT_W-1:0];
          fca_pkg::REG_AVERAGE_ENABLE: avg_on_reg <= pwdata[0];
          fca_pkg::REG_RMS_ENABLE:     rms_on_reg <= pwdata[0];
          default: ;
        endcase
      end

      // compare an accepted result word
      if (result_valid && result_ready) begin
        got_w = '{pixel_index, average_value, rms_value, average_valid, rms_valid,
                  last_in_frame};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, index %0d", $realtime, pixel_index);
          errors++;
        end else begin
          want_w = expected_words.pop_front();
          check_field("pixel_index", want_w.index, got_w.index);
          check_field("average_value", want_w.average, got_w.average);
          check_field("rms_value", want_w.rms, got_w.rms);
          check_field("average_valid", want_w.avg_on, got_w.avg_on);
          check_field("rms_valid", want_w.rms_on, got_w.rms_on);
          check_field("last_in_frame", want_w.last, got_w.last);
        end
      end

      // accumulate an accepted pixel and predict its result
      if (pixel_valid && pixel_ready) begin
        v     = longint'(pixel_value);
        fsize = (frame_size_reg == 0) ? 1 :
                (frame_size_reg > PIXELS_MAX) ? PIXELS_MAX : int'(frame_size_reg);
        csize = (coadd_reg == 0) ? 1 :
                (coadd_reg > FRAMES_MAX) ? FRAMES_MAX : int'(coadd_reg);
        pos   = (position >= PIXELS_MAX) ? PIXELS_MAX - 1 : position;
        if (frame_count == 0) begin
          pixel_sum[pos] = v;
          if (rms_on_reg) square_sum[pos] = longint'(v * v);
        end else begin
          pixel_sum[pos] += v;
          if (rms_on_reg) square_sum[pos] += longint'(v * v);
        end
        count = frame_count + 1;
        done  = count >= csize;
        last  = pos + 1 >= fsize;
        if (done && (avg_on_reg || rms_on_reg)) begin
          avg  = 0;
          root = 0;
          if (avg_on_reg) begin
            num = pixel_sum[pos] * 256;
            avg = num / count;
            if (num % count != 0 && num < 0) avg -= 1;
            if (avg > 8388607) avg = 8388607;
            if (avg < -8388608) avg = -8388608;
          end
          if (rms_on_reg) begin
            sq     = square_sum[pos];
            scaled = ((sq / count) << 16) + (((sq % count) << 16) / count);
            root   = int_sqrt(scaled);
            if (root > 64'hFFFFFF) root = 64'hFFFFFF;
          end
          want_w.index   = pos[fca_pkg::INDEX_W-1:0];
          want_w.average = avg[fca_pkg::RESULT_W-1:0];
          want_w.rms     = root[fca_pkg::RESULT_W-1:0];
          want_w.avg_on  = avg_on_reg;
          want_w.rms_on  = rms_on_reg;
          want_w.last    = last;
          expected_words.push_back(want_w);
        end
        if (last) begin
          position    <= 0;
          frame_count <= done ? 0 : count;
        end else begin
          position <= pos + 1;
        end
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the frame co-add block: configures whole co-add runs over the
// register port, streams pixels in random bursts against a stalling result
// sink, and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_WAIT  = 150;
  localparam int RANDOM_PIXELS = 60;

  logic                                clk;
  logic                                rst;
  logic                                pixel_valid;
  logic                                pixel_ready;
  logic signed [15:0]                  pixel_value;
  logic                                result_valid;
  logic                                result_ready;
  logic [fca_pkg::INDEX_W-1:0]         pixel_index;
  logic signed [fca_pkg::RESULT_W-1:0] average_value;
  logic [fca_pkg::RESULT_W-1:0]        rms_value;
  logic                                average_valid;
  logic                                rms_valid;
  logic                                last_in_frame;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [fca_pkg::ADDR_W-1:0]          paddr;
  logic [fca_pkg::DATA_W-1:0]          pwdata;
  logic [fca_pkg::DATA_W-1:0]          prdata;
  logic                                pready;
  int                                  errors;
  int                                  pending;
  int                                  cycles;
  int                                  burst_left;
  int                                  stall_mode;
  int                                  stall_left;

  frame_coadd_average_rms dut (.*);

  coadd_checker chk (
    .clk, .rst, .pixel_valid, .pixel_ready, .pixel_value, .result_valid,
    .result_ready, .pixel_index, .average_value, .rms_value, .average_valid,
    .rms_valid, .last_in_frame, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("frame_coadd_average_rms test failed");
      $finish;
    end
  end

  // result sink: stretches of full rate, random stalls and long stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_mode   <= 0;
      stall_left   <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(10, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ($urandom_range(0, 3) != 0);
        default: result_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [fca_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one pixel word, with bursts and gaps between them
  task automatic send_pixel(input logic signed [15:0] v);
    logic taken;
    if (burst_left == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    pixel_valid <= 1'b1;
    pixel_value <= v;
    do begin
      @(negedge clk);
      taken = pixel_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // let the pipeline empty before the registers change
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_run(input int fsize, input int csize, input bit avg_on,
                         input bit rms_on);
    write_reg(fca_pkg::REG_FRAME_PIXELS, fsize);
    write_reg(fca_pkg::REG_COADD_COUNT, csize);
    write_reg(fca_pkg::REG_AVERAGE_ENABLE, fca_pkg::DATA_W'(avg_on));
    write_reg(fca_pkg::REG_RMS_ENABLE, fca_pkg::DATA_W'(rms_on));
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel());
    drain();
  endtask

  initial begin
    logic signed [15:0] corner [6];
    int fsize;
    int csize;
    int sent;
    corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555};
    rst         = 1'b1;
    pixel_valid = 1'b0;
    pixel_value = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    burst_left  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-pixel frames with the extreme samples, both outputs on
    set_run(1, 1, 1, 1);
    foreach (corner[i]) send_pixel(corner[i]);
    drain();
    // zero frame size and zero coadd count
    set_run(0, 0, 1, 0);
    run_random(4);
    // rms only, then nothing enabled, then both
    set_run(4, 3, 0, 1);
    run_random(12);
    set_run(3, 2, 0, 0);
    run_random(6);
    set_run(5, 2, 1, 1);
    run_random(10);
    // frame size shrunk mid-run below the current position
    set_run(8, 3, 1, 1);
    run_random(13);
    set_run(3, 3, 1, 1);
    run_random(4);
    // coadd count above the maximum
    set_run(1, 2047, 1, 1);
    run_random(1024);
    // frame size above the maximum, then a shrunk frame wraps the position
    set_run(131071, 1, 1, 1);
    run_random(64);
    set_run(1, 1, 1, 1);
    run_random(1);

    // random runs of small frames
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      fsize = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      csize = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      set_run(fsize, csize, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_random((fsize == 0 ? 1 : fsize) * (csize == 0 ? 1 : csize));
      sent += (fsize == 0 ? 1 : fsize) * (csize == 0 ? 1 : csize);
    end

    if (errors == 0 && pending == 0) begin
      $display("frame_coadd_average_rms test passed");
    end else begin
      $display("frame_coadd_average_rms test failed");
    end
    $finish;
  end

endmodule
